/* src/windowed_reorder_receiver_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the windowed reorder receiver
// Concurrent checks clocked by aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_REORDER_RECEIVER_MACROS_SVH
`define WINDOWED_REORDER_RECEIVER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WRR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("windowed_reorder_receiver check failed");
// next-cycle implication
`define WRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("windowed_reorder_receiver check failed");
`else
`define WRR_ASSERT_NOW(label, ante, cons)
`define WRR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/wrr_pkg.sv */
// ----------------------------------------------------------------------------
// wrr_pkg
// Shared widths, reset values, codes and types of the reorder receiver.
// ----------------------------------------------------------------------------
package wrr_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

    localparam int SEQ_W   = 16;
    localparam int TAG_W   = 16;
    localparam int BYTES_W = 10;
    localparam int WLIM_W  = 5;

    localparam logic [WLIM_W-1:0] WLIM_RESET = WLIM_W'(10);
    localparam logic [SEQ_W-1:0]  LIO_RESET  = {SEQ_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_FINAL   = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [TAG_W-1:0]   tag;
        logic [SEQ_W-1:0]   seq;
    } entry_t;

    // clamp the window register into 1..MAX_WINDOW
    function automatic logic [CNT_W-1:0] eff_limit(input logic [WLIM_W-1:0] wl);
        logic [CNT_W-1:0] r;
        if (wl == '0) begin
            r = CNT_W'(1);
        end else if (32'(wl) > MAX_WINDOW) begin
            r = CNT_W'(MAX_WINDOW);
        end else begin
            r = CNT_W'(wl);
        end
        return r;
    endfunction

endpackage

/* src/wrr_ram.sv */
// ----------------------------------------------------------------------------
// wrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/windowed_reorder_receiver.sv */
// ----------------------------------------------------------------------------
// windowed_reorder_receiver
// Reorders received segment headers through a small window store and issues
// deliveries, window replies and a final acknowledgement.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata 48b, tuser 2b, tlast
//  m_       | out       | m_tvalid/m_tready  | tdata 64b, tuser 2b, tlast
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_data 5b (window_limit)
//
// One item at a time: a duplicate search reads every held entry, then a flush
// of a disordered window reads the entries after each output position to find
// the next smallest; the single store read port sets this pace.
// aresetn (synchronous, active low) clears all control state; the store holds
// no reset and is only read below the fill count.
// A stalled m_tready holds the sequencer in its emit step; s_tready stays low
// until every result of the current item has been loaded into the output.
// ----------------------------------------------------------------------------
`include "windowed_reorder_receiver_macros.svh"

module windowed_reorder_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // seq_number[15:0], payload_tag[31:16],
                                   // payload_bytes[41:32], zero fill
    input  logic [1:0]  s_tuser,   // is_data[0], is_window_request[1]
    input  logic        s_tlast,   // is_end
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_seq[15:0], ack_value[31:16],
                                   // ack_flag[32], window_adv[37:33],
                                   // out_tag[53:38], out_bytes[63:54]
    output logic [1:0]  m_tuser,   // out_kind
    output logic        m_tlast,   // last_of_run
    // window_limit register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    localparam int SW = wrr_pkg::SEQ_W;
    localparam int CW = wrr_pkg::CNT_W;
    localparam int AW = wrr_pkg::ADDR_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DUP_RD,
        ST_DUP_CHK,
        ST_DECIDE,
        ST_FL_RD_I,
        ST_FL_GET_I,
        ST_FL_RD_J,
        ST_FL_CMP_J,
        ST_FL_EMIT,
        ST_REPLY,
        ST_FINAL
    } state_t;

    state_t state_reg;

    // architectural state
    logic [wrr_pkg::WLIM_W-1:0] wlim_reg;
    logic [SW-1:0]              lio_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       disorder_reg;
    logic [SW-1:0]              dcount_reg;
    logic [SW-1:0]              ldseq_reg;

    // latched item
    wrr_pkg::entry_t item_reg;
    logic            dat_reg;
    logic            rwa_reg;
    logic            eom_reg;
    logic            dup_reg;
    logic            flushed_reg;

    // scan indexes and flush working entries
    logic [CW-1:0]   idx_reg;   // search index / flush position i
    logic [CW-1:0]   j_reg;
    logic [CW-1:0]   m_reg;
    wrr_pkg::entry_t cur_reg;
    wrr_pkg::entry_t min_reg;

    // output register
    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic [1:0]  m_user_reg;
    logic        m_last_reg;

    // store port
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    wrr_pkg::entry_t ram_wdata;
    logic [AW-1:0]   ram_raddr;
    wrr_pkg::entry_t ram_rdata;

    logic            out_free;
    logic            out_load;
    logic [CW-1:0]   eff;
    logic [SW-1:0]   next_seq;
    logic            hold_run;
    logic            hold_ahead;
    logic            room;

    assign out_free  = !m_valid_reg || m_tready;
    // an emit step loads the output register this cycle
    assign out_load  = out_free && (state_reg inside {ST_FL_EMIT, ST_REPLY, ST_FINAL});
    assign eff       = wrr_pkg::eff_limit(wlim_reg);
    assign next_seq  = lio_reg + SW'(1);
    assign room      = cnt_reg < eff;
    // in-run data takes priority; ahead-of-run data needs a fresh number
    assign hold_run   = dat_reg && (next_seq == item_reg.seq);
    assign hold_ahead = !hold_run && dat_reg && !dup_reg && (item_reg.seq >= lio_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign m_tlast   = m_last_reg;

    // store write: hold a new entry, or park entry i where the minimum was
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[AW-1:0];
        ram_wdata = item_reg;
        if (state_reg == ST_DECIDE) begin
            ram_we = (hold_run || hold_ahead) && room && !(dup_reg && !rwa_reg);
        end else if (state_reg == ST_FL_EMIT) begin
            ram_we    = out_free && (m_reg != idx_reg);
            ram_waddr = m_reg[AW-1:0];
            ram_wdata = cur_reg;
        end
    end

    always_comb begin
        case (state_reg)
            ST_FL_RD_J: ram_raddr = j_reg[AW-1:0];
            default:    ram_raddr = idx_reg[AW-1:0];
        endcase
    end

    wrr_ram #(
        .WIDTH ($bits(wrr_pkg::entry_t)),
        .DEPTH (wrr_pkg::MAX_WINDOW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wlim_reg     <= wrr_pkg::WLIM_RESET;
            lio_reg      <= wrr_pkg::LIO_RESET;
            cnt_reg      <= '0;
            disorder_reg <= 1'b0;
            dcount_reg   <= '0;
            ldseq_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                wlim_reg <= cfg_data;
            end
            // drop the sent item unless an emit step reloads the output
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        item_reg.seq   <= s_tdata[15:0];
                        item_reg.tag   <= s_tdata[31:16];
                        item_reg.bytes <= s_tdata[41:32];
                        dat_reg     <= s_tuser[0];
                        rwa_reg     <= s_tuser[1];
                        eom_reg     <= s_tlast;
                        dup_reg     <= 1'b0;
                        flushed_reg <= 1'b0;
                        idx_reg     <= '0;
                        state_reg   <= (cnt_reg == '0) ? ST_DECIDE : ST_DUP_RD;
                    end
                end
                ST_DUP_RD: begin
                    state_reg <= ST_DUP_CHK;
                end
                ST_DUP_CHK: begin
                    if (ram_rdata.seq == item_reg.seq) begin
                        dup_reg <= 1'b1;
                    end
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= (idx_reg + CW'(1) == cnt_reg) ? ST_DECIDE : ST_DUP_RD;
                end
                ST_DECIDE: begin
                    idx_reg <= '0;
                    if (dup_reg && !rwa_reg) begin
                        // drop a repeated segment
                        state_reg <= ST_IDLE;
                    end else begin
                        if (hold_run) begin
                            if (room) begin
                                lio_reg <= item_reg.seq;
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                        end else if (hold_ahead) begin
                            if (room) begin
                                disorder_reg <= 1'b1;
                                cnt_reg      <= cnt_reg + CW'(1);
                            end
                        end else if (rwa_reg && (next_seq == item_reg.seq)) begin
                            lio_reg <= item_reg.seq;
                        end
                        if (eom_reg) begin
                            state_reg <= ST_FL_RD_I;
                        end else if (rwa_reg) begin
                            if ((item_reg.seq != '0) &&
                                (cnt_reg + CW'((hold_run || hold_ahead) && room) >= eff)) begin
                                flushed_reg <= 1'b1;
                                state_reg   <= ST_FL_RD_I;
                            end else begin
                                state_reg <= ST_REPLY;
                            end
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_FL_RD_I: begin
                    if (idx_reg == cnt_reg) begin
                        // store drained: reset window bookkeeping
                        cnt_reg      <= '0;
                        disorder_reg <= 1'b0;
                        state_reg    <= eom_reg ? ST_FINAL : ST_REPLY;
                    end else begin
                        state_reg <= ST_FL_GET_I;
                    end
                end
                ST_FL_GET_I: begin
                    cur_reg <= ram_rdata;
                    min_reg <= ram_rdata;
                    m_reg   <= idx_reg;
                    j_reg   <= idx_reg + CW'(1);
                    if (disorder_reg && (idx_reg + CW'(1) < cnt_reg)) begin
                        state_reg <= ST_FL_RD_J;
                    end else begin
                        state_reg <= ST_FL_EMIT;
                    end
                end
                ST_FL_RD_J: begin
                    state_reg <= ST_FL_CMP_J;
                end
                ST_FL_CMP_J: begin
                    // first strictly smaller number wins
                    if (ram_rdata.seq < min_reg.seq) begin
                        min_reg <= ram_rdata;
                        m_reg   <= j_reg;
                    end
                    j_reg     <= j_reg + CW'(1);
                    state_reg <= (j_reg + CW'(1) == cnt_reg) ? ST_FL_EMIT : ST_FL_RD_J;
                end
                ST_FL_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= wrr_pkg::KIND_DELIVER;
                        m_last_reg  <= 1'b0;
                        m_data_reg  <= {min_reg.bytes, min_reg.tag, 5'd0, 1'b0,
                                        16'd0, min_reg.seq};
                        ldseq_reg   <= min_reg.seq;
                        dcount_reg  <= dcount_reg + SW'(1);
                        idx_reg     <= idx_reg + CW'(1);
                        state_reg   <= ST_FL_RD_I;
                    end
                end
                ST_REPLY: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= wrr_pkg::KIND_REPLY;
                        m_last_reg  <= 1'b1;
                        if (item_reg.seq == '0) begin
                            m_data_reg <= {26'd0, wlim_reg, 1'b0, 16'd0, 16'd0};
                        end else if (flushed_reg) begin
                            m_data_reg <= {26'd0, wlim_reg, 1'b1, dcount_reg, 16'd0};
                        end else begin
                            m_data_reg <= {26'd0, wlim_reg, 1'b1, lio_reg, 16'd0};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FINAL: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_user_reg   <= wrr_pkg::KIND_FINAL;
                        m_last_reg   <= 1'b1;
                        m_data_reg   <= {26'd0, wlim_reg, 1'b1, ldseq_reg, ldseq_reg};
                        // end of message: back to reset values
                        lio_reg      <= wrr_pkg::LIO_RESET;
                        cnt_reg      <= '0;
                        disorder_reg <= 1'b0;
                        dcount_reg   <= '0;
                        ldseq_reg    <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `WRR_ASSERT_NOW(a_cnt_bound, 1'b1, 32'(cnt_reg) <= wrr_pkg::MAX_WINDOW)
    `WRR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `WRR_ASSERT_NOW(a_final_is_last, m_tvalid && (m_tuser == wrr_pkg::KIND_FINAL), m_tlast)
    `WRR_ASSERT_NOW(a_delivery_not_last, m_tvalid && (m_tuser == wrr_pkg::KIND_DELIVER), !m_tlast)

endmodule

/* tb/wrr_checker.sv */
// ----------------------------------------------------------------------------
// wrr_checker
// Watches the input, result and window register channels of the reorder
// receiver, predicts the results of every accepted item and compares them
// field by field in arrival order.
// ----------------------------------------------------------------------------
module wrr_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [63:0] data;
    } result_t;

    result_t                     awaited[$];
    logic [wrr_pkg::WLIM_W-1:0]  win_reg;
    logic [wrr_pkg::SEQ_W-1:0]   in_order;
    wrr_pkg::entry_t             store[wrr_pkg::MAX_WINDOW];
    int                          fill;
    bit                          unsorted;
    logic [15:0]                 sent_total;
    logic [wrr_pkg::SEQ_W-1:0]   sent_last;

    assign pending = awaited.size();

    function automatic int clamp_window();
        if (win_reg == 0) return 1;
        if (win_reg > wrr_pkg::MAX_WINDOW) return wrr_pkg::MAX_WINDOW;
        return int'(win_reg);
    endfunction

    task automatic clear_window();
        in_order = wrr_pkg::LIO_RESET;
        fill = 0;
        unsorted = 0;
        sent_total = '0;
        sent_last = '0;
    endtask

    task automatic push_result(logic [1:0] kind, logic [15:0] seq, logic [15:0] ack,
                               logic flag, logic [4:0] adv, logic [15:0] tag,
                               logic [9:0] nbytes);
        result_t r;
        r.kind = kind;
        r.last = 0;
        r.data = {nbytes, tag, adv, flag, ack, seq};
        awaited.push_back(r);
    endtask

    task automatic drain_window();
        wrr_pkg::entry_t t;
        int m;
        if (unsorted) begin
            for (int i = 0; i < fill; i++) begin
                m = i;
                for (int j = i + 1; j < fill; j++)
                    if (store[j].seq < store[m].seq) m = j;
                if (m != i) begin
                    t = store[i]; store[i] = store[m]; store[m] = t;
                end
            end
        end
        for (int i = 0; i < fill; i++) begin
            push_result(wrr_pkg::KIND_DELIVER, store[i].seq, 16'd0, 1'b0, 5'd0,
                        store[i].tag, store[i].bytes);
            sent_last = store[i].seq;
            sent_total = sent_total + 16'd1;
        end
        fill = 0;
        unsorted = 0;
    endtask

    task automatic predict_segment(logic [47:0] d, logic [1:0] u, logic eom);
        logic [15:0] seq, nxt;
        logic dat, rwa, dup, room;
        int n0;
        seq = d[15:0];
        dat = u[0];
        rwa = u[1];
        nxt = in_order + 16'd1;
        dup = 0;
        room = fill < clamp_window();
        n0 = awaited.size();
        for (int i = 0; i < fill; i++)
            if (store[i].seq == seq) dup = 1;
        if (dup && !rwa) return;
        if (dat && nxt == seq) begin
            if (room) begin
                in_order = seq;
                store[fill] = '{bytes: d[41:32], tag: d[31:16], seq: seq};
                fill++;
            end
        end else if (dat && !dup && seq >= in_order) begin
            if (room) begin
                unsorted = 1;
                store[fill] = '{bytes: d[41:32], tag: d[31:16], seq: seq};
                fill++;
            end
        end else if (rwa && nxt == seq) begin
            in_order = seq;
        end
        if (rwa && !eom) begin
            if (seq == 0) begin
                push_result(wrr_pkg::KIND_REPLY, 16'd0, 16'd0, 1'b0, win_reg, 16'd0, 10'd0);
            end else if (fill >= clamp_window()) begin
                drain_window();
                push_result(wrr_pkg::KIND_REPLY, 16'd0, sent_total, 1'b1, win_reg,
                            16'd0, 10'd0);
            end else begin
                push_result(wrr_pkg::KIND_REPLY, 16'd0, in_order, 1'b1, win_reg,
                            16'd0, 10'd0);
            end
        end
        if (eom) begin
            drain_window();
            push_result(wrr_pkg::KIND_FINAL, sent_last, sent_last, 1'b1, win_reg,
                        16'd0, 10'd0);
            clear_window();
        end
        if (awaited.size() > n0) awaited[$].last = 1;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        win_reg = wrr_pkg::WLIM_RESET;
        clear_window();
    end

    always @(posedge aclk) begin
        result_t w;
        if (!aresetn) begin
            win_reg = wrr_pkg::WLIM_RESET;
            clear_window();
        end else begin
            if (cfg_valid && cfg_ready) win_reg = cfg_data;
            // results of an earlier item may leave in this cycle; they sit
            // ahead of anything the new item adds
            if (m_tvalid && m_tready) begin
                if (awaited.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 64'd0);
                end else begin
                    w = awaited.pop_front();
                    if (m_tuser !== w.kind)
                        report_mismatch("out_kind", 64'(m_tuser), 64'(w.kind));
                    if (m_tlast !== w.last)
                        report_mismatch("last_of_run", 64'(m_tlast), 64'(w.last));
                    if (m_tdata[15:0] !== w.data[15:0])
                        report_mismatch("out_seq", 64'(m_tdata[15:0]), 64'(w.data[15:0]));
                    if (m_tdata[31:16] !== w.data[31:16])
                        report_mismatch("ack_value", 64'(m_tdata[31:16]),
                                        64'(w.data[31:16]));
                    if (m_tdata[32] !== w.data[32])
                        report_mismatch("ack_flag", 64'(m_tdata[32]), 64'(w.data[32]));
                    if (m_tdata[37:33] !== w.data[37:33])
                        report_mismatch("window_adv", 64'(m_tdata[37:33]),
                                        64'(w.data[37:33]));
                    if (m_tdata[53:38] !== w.data[53:38])
                        report_mismatch("out_tag", 64'(m_tdata[53:38]),
                                        64'(w.data[53:38]));
                    if (m_tdata[63:54] !== w.data[63:54])
                        report_mismatch("out_bytes", 64'(m_tdata[63:54]),
                                        64'(w.data[63:54]));
                end
            end
            if (s_tvalid && s_tready) predict_segment(s_tdata, s_tuser, s_tlast);
        end
    end
endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the reorder receiver: directed segments, then random
// messages built mostly from in-order and shuffled runs, under several window
// settings, with bursty input, a patterned result stall and one long hold-off.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    int          fail_count;
    int          pending;

    // idle-cycle watchdog: its limit must outlast a full sorted flush and the long
    // hold-off
    localparam int IDLE_LIMIT = 20000;
    int  idle_cycles = 0;
    bit  hold_off = 0;

    windowed_reorder_receiver uut (.*);

    wrr_checker checker_i (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // stall the result side on a rolling pattern; hold off during pressure
    always @(negedge aclk) begin
        logic [7:0] pat;
        pat = 8'($urandom);
        if (hold_off) m_tready <= 0;
        else if (pat[7:6] == 0) m_tready <= 1;
        else m_tready <= pat[1:0] != 0;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    int burst_left = 0;

    // offer one segment and hold it until accepted; gaps between bursts
    task automatic send_segment(logic [15:0] seq, bit dat, bit rwa, bit eom,
                                logic [15:0] tag, logic [9:0] nbytes);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid = 1;
        s_tdata <= {6'd0, nbytes, tag, seq};
        s_tuser <= {rwa, dat};
        s_tlast <= eom;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic send_random_payload(logic [15:0] seq, bit dat, bit rwa, bit eom);
        send_segment(seq, dat, rwa, eom, 16'($urandom), 10'($urandom_range(0, 512)));
    endtask

    // wait for all results, let the block settle, then write the window
    task automatic set_window(logic [4:0] v);
        while (pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // one message: in-order run with shuffling, requests, noise, then end
    task automatic send_message(int len);
        logic [15:0] seqs[$];
        int a, b;
        logic [15:0] t;
        for (int i = 0; i < len; i++) seqs.push_back(16'(i));
        for (int i = 0; i < len / 3; i++) begin
            a = $urandom_range(0, len - 1);
            b = $urandom_range(0, len - 1);
            t = seqs[a]; seqs[a] = seqs[b]; seqs[b] = t;
        end
        foreach (seqs[i]) begin
            case ($urandom_range(0, 9))
                0: send_random_payload(16'($urandom), 1'($urandom), 1'($urandom), 0);
                1: send_random_payload(seqs[i], 0, 1, 0);
                2: send_random_payload(seqs[i], 1, 1, 0);
                default: send_random_payload(seqs[i], 1, 0, 0);
            endcase
            if ($urandom_range(0, 3) == 0)
                send_random_payload(seqs[i], 1'($urandom), 1, 0);
        end
        send_random_payload(16'($urandom_range(0, len)), 1'($urandom), 1'($urandom), 1);
    endtask

    initial begin
        logic [4:0] wins[6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd10};
        repeat (12) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // first request, in-order data, flush by request, duplicates, full store
        send_segment(16'd0, 0, 1, 0, 16'hFFFF, 10'd512);
        send_segment(16'd0, 1, 0, 0, 16'h0000, 10'd0);
        send_segment(16'd0, 1, 0, 0, 16'h1234, 10'd7);
        send_segment(16'd0, 1, 1, 1, 16'h0001, 10'd1);
        send_segment(16'd0, 1, 0, 1, 16'hFFFF, 10'd512);
        send_segment(16'd0, 1, 0, 1, 16'hFFFF, 10'd512);
        set_window(5'd2);
        send_segment(16'd0, 1, 0, 0, 16'hAAAA, 10'd3);
        send_segment(16'd5, 1, 0, 0, 16'h5555, 10'd4);
        send_segment(16'd2, 1, 0, 0, 16'h0F0F, 10'd5);
        send_segment(16'd1, 0, 1, 0, 16'h0, 10'd0);
        send_segment(16'd9, 1, 1, 0, 16'h0, 10'd0);
        send_segment(16'hFFFF, 1, 0, 0, 16'h0, 10'd0);
        send_segment(16'd3, 0, 1, 1, 16'h0, 10'd0);
        send_segment(16'd7, 0, 0, 1, 16'h0, 10'd0);

        // pressure: hold off the result side while segments keep coming
        set_window(5'd16);
        fork
            begin
                hold_off = 1;
                repeat (600) @(negedge aclk);
                hold_off = 0;
            end
            send_message(20);
        join

        foreach (wins[w]) begin
            set_window(wins[w]);
            for (int m = 0; m < 4; m++) send_message($urandom_range(2, 14));
        end
        while (pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
